[src/nir_moisture_measure_unit_defines.svh]
// Assertion macros used by the checker file.
`ifndef NIR_MOISTURE_MEASURE_UNIT_DEFINES_SVH
`define NIR_MOISTURE_MEASURE_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define NMMU_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked on every clock edge, reset included.
`define NMMU_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[src/nmmu_pkg.sv]
package nmmu_pkg;

    // Field widths
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned MOIST_W  = 10;
    localparam int unsigned GAIN_W   = 4;
    localparam int unsigned ATT_W    = 2;

    // Stream and config port widths
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 32;
    localparam int unsigned OUT_USER_W = STATUS_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Divider sizing: dividend 2000*n + den stays below 2^27
    localparam int unsigned SCALE_W = 11;
    localparam int unsigned REM_W   = 27;
    localparam int unsigned DSR_W   = CNT_W + 1 + MOIST_W - 1;
    localparam int unsigned LOOP_W  = 4;

    localparam logic [ATT_W-1:0]   MAX_ATTEMPTS     = 2'd3;
    localparam logic [CNT_W-1:0]   DEF_DRY          = 16'd1500;
    localparam logic [CNT_W-1:0]   DEF_WET          = 16'd300;
    localparam logic [CNT_W-1:0]   MIN_INTERVAL_RST = 16'd500;
    localparam logic [CNT_W-1:0]   SAT_LEVEL_RST    = 16'hFFFF;
    localparam logic [GAIN_W-1:0]  GAIN_RST         = 4'd7;
    localparam logic [MOIST_W-1:0] MOIST_FULL       = 10'd1000;
    localparam logic [SCALE_W-1:0] MOIST_SCALE      = 11'd2000;
    localparam logic [LOOP_W-1:0]  DIV_LAST         = LOOP_W'(MOIST_W - 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_TOO_FREQUENT = 3'd1,
        ST_READ_RETRY   = 3'd2,
        ST_GAIN_RETRY   = 3'd3,
        ST_FAILED       = 3'd4,
        ST_OK_MINSAT    = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRY          = 3'd0,
        CFG_WET          = 3'd1,
        CFG_CAL_VALID    = 3'd2,
        CFG_MIN_INTERVAL = 3'd3,
        CFG_SAT_LEVEL    = 3'd4
    } cfg_index_t;

    // Microcode
    typedef enum logic [2:0] {
        OP_NOP,
        OP_WAIT_IN,
        OP_DECIDE,
        OP_SETUP,
        OP_DIV,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_IN,
        COND_DONE,
        COND_LOOP,
        COND_OUT_BUSY
    } cond_t;

    localparam int unsigned PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctl_word_t;

    localparam pc_t PC_START  = 3'd0;
    localparam pc_t PC_DECIDE = 3'd1;
    localparam pc_t PC_SETUP  = 3'd2;
    localparam pc_t PC_DIV    = 3'd3;
    localparam pc_t PC_EMIT   = 3'd4;
    localparam pc_t PC_RETURN = 3'd5;

    // Program: jump to target when the condition holds, else fall through
    function automatic ctl_word_t ucode_rom(input pc_t pc);
        ctl_word_t w;
        case (pc)
            PC_START:  w = '{op: OP_WAIT_IN, cond: COND_NO_IN,    target: PC_START};
            PC_DECIDE: w = '{op: OP_DECIDE,  cond: COND_DONE,     target: PC_EMIT};
            PC_SETUP:  w = '{op: OP_SETUP,   cond: COND_DONE,     target: PC_EMIT};
            PC_DIV:    w = '{op: OP_DIV,     cond: COND_LOOP,     target: PC_DIV};
            PC_EMIT:   w = '{op: OP_EMIT,    cond: COND_OUT_BUSY, target: PC_EMIT};
            PC_RETURN: w = '{op: OP_NOP,     cond: COND_ALWAYS,   target: PC_START};
            default:   w = '{op: OP_NOP,     cond: COND_ALWAYS,   target: PC_START};
        endcase
        return w;
    endfunction

endpackage

[src/nir_moisture_measure_unit.sv]
// NIR moisture measurement unit. Each input item is one measurement attempt
// (time, LED-off and LED-on counts, read-ok flags); each produces exactly one
// result item with a status, paper detection, moisture in tenths of a percent,
// the reflected count and the gain code to program next. A small microcode
// program steps the datapath: it takes the item, decides, then for paper runs
// a setup step and, unless the moisture clamps at 0 or 1000, ten steps of a
// restoring divider; it then hands the result to the output register and
// returns. Items whose moisture needs the division take longest, because of
// the ten-step division loop. A finished result waits in the output register
// while the next item is taken; the sequencer stalls only when a second result
// is ready before the first has been taken, and then for as long as it waits.
// Configuration writes are always ready and take effect at once.
module nir_moisture_measure_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: now_ms[31:0], ambient_nir[47:32], lit_nir[63:48]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [nmmu_pkg::IN_DATA_W-1:0]      s_tdata,
    // tuser: ambient_ok[0], lit_ok[1]
    input  logic [nmmu_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: paper_detected[0], moisture_tenths[10:1], reflected_nir[26:11],
    //        gain_setting[30:27], zero[31]
    output logic [nmmu_pkg::OUT_DATA_W-1:0]     m_tdata,
    // tuser: status[2:0]
    output logic [nmmu_pkg::OUT_USER_W-1:0]     m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nmmu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nmmu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import nmmu_pkg::*;

    // Configuration registers
    logic [CNT_W-1:0]   dry_reg, dry_next;
    logic [CNT_W-1:0]   wet_reg, wet_next;
    logic               cal_reg, cal_next;
    logic [CNT_W-1:0]   min_int_reg, min_int_next;
    logic [CNT_W-1:0]   sat_reg, sat_next;

    // Measurement state
    logic [GAIN_W-1:0]  gain_reg, gain_next;
    logic [TIME_W-1:0]  last_start_reg, last_start_next;
    logic               open_reg, open_next;
    logic [ATT_W-1:0]   att_reg, att_next;

    // Sequencer
    pc_t                pc_reg, pc_next;
    ctl_word_t          ctl;
    logic               in_accept;
    logic               out_free;
    logic               done;
    logic               take;

    // Latched input item
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [CNT_W-1:0]   amb_reg, amb_next;
    logic [CNT_W-1:0]   lit_reg, lit_next;
    logic               amb_ok_reg, amb_ok_next;
    logic               lit_ok_reg, lit_ok_next;

    // Work registers
    status_t            status_reg, status_next;
    logic               paper_reg, paper_next;
    logic [CNT_W-1:0]   refl_reg, refl_next;
    logic [MOIST_W-1:0] moist_reg, moist_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [DSR_W-1:0]   dsr_reg, dsr_next;
    logic [LOOP_W-1:0]  loop_reg, loop_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    status_t            out_status_reg, out_status_next;
    logic               out_paper_reg, out_paper_next;
    logic [MOIST_W-1:0] out_moist_reg, out_moist_next;
    logic [CNT_W-1:0]   out_refl_reg, out_refl_next;
    logic [GAIN_W-1:0]  out_gain_reg, out_gain_next;

    // Decision terms
    logic [TIME_W-1:0]  elapsed;
    logic               too_soon;
    logic               gain_nz;
    logic               amb_sat, lit_sat;
    logic               amb_lower, lit_lower;
    logic               retry_read, retry_gain, min_sat;
    logic [ATT_W-1:0]   att_inc;
    logic               exhausted;
    logic [CNT_W-1:0]   refl;
    logic [CNT_W+1:0]   refl2, amb3;
    logic               paper;

    // Moisture setup terms
    logic               use_cal;
    logic [CNT_W-1:0]   dry_act, wet_act, den;
    logic [CNT_W:0]     num;
    logic               num_le0, num_ge_den;
    logic [REM_W-1:0]   div_trial;
    logic               div_bit;

    assign cfg_ready = 1'b1;
    assign ctl       = ucode_rom(pc_reg);
    assign s_tready  = (ctl.op == OP_WAIT_IN);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_gain_reg, out_refl_reg, out_moist_reg, out_paper_reg};

    // Interval, read and saturation checks
    assign elapsed    = now_reg - last_start_reg;
    assign too_soon   = !open_reg && (elapsed < {{(TIME_W-CNT_W){1'b0}}, min_int_reg});
    assign gain_nz    = (gain_reg != '0);
    assign amb_sat    = (amb_reg >= sat_reg);
    assign lit_sat    = (lit_reg >= sat_reg);
    assign amb_lower  = amb_sat && gain_nz;
    assign lit_lower  = lit_sat && gain_nz;
    assign retry_read = !amb_ok_reg || (!amb_lower && !lit_ok_reg);
    assign retry_gain = amb_ok_reg && (amb_lower || (lit_ok_reg && lit_lower));
    assign min_sat    = (amb_sat || lit_sat) && !gain_nz;
    assign att_inc    = (open_reg ? att_reg : '0) + ATT_W'(1);
    assign exhausted  = (att_inc >= MAX_ATTEMPTS);

    // Reflected light and paper test: 2*refl > 3*amb
    assign refl  = (lit_reg > amb_reg) ? (lit_reg - amb_reg) : '0;
    assign refl2 = {1'b0, refl, 1'b0};
    assign amb3  = {1'b0, amb_reg, 1'b0} + {2'b00, amb_reg};
    assign paper = (refl2 > amb3);

    // Active baselines and numerator
    assign use_cal    = cal_reg && (dry_reg > wet_reg);
    assign dry_act    = use_cal ? dry_reg : DEF_DRY;
    assign wet_act    = use_cal ? wet_reg : DEF_WET;
    assign den        = dry_act - wet_act;
    assign num        = {1'b0, dry_act} - {1'b0, refl_reg};
    assign num_le0    = num[CNT_W] || (num == '0);
    assign num_ge_den = !num[CNT_W] && (num[CNT_W-1:0] >= den);

    // One restoring division step
    assign div_bit   = ({1'b0, dsr_reg} <= rem_reg);
    assign div_trial = rem_reg - {1'b0, dsr_reg};

    // Datapath control and next state
    always_comb begin
        dry_next        = dry_reg;
        wet_next        = wet_reg;
        cal_next        = cal_reg;
        min_int_next    = min_int_reg;
        sat_next        = sat_reg;
        gain_next       = gain_reg;
        last_start_next = last_start_reg;
        open_next       = open_reg;
        att_next        = att_reg;
        now_next        = now_reg;
        amb_next        = amb_reg;
        lit_next        = lit_reg;
        amb_ok_next     = amb_ok_reg;
        lit_ok_next     = lit_ok_reg;
        status_next     = status_reg;
        paper_next      = paper_reg;
        refl_next       = refl_reg;
        moist_next      = moist_reg;
        rem_next        = rem_reg;
        dsr_next        = dsr_reg;
        loop_next       = loop_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_paper_next  = out_paper_reg;
        out_moist_next  = out_moist_reg;
        out_refl_next   = out_refl_reg;
        out_gain_next   = out_gain_reg;
        done            = 1'b0;

        // Register writes
        if (cfg_valid) begin
            case (cfg_index)
                CFG_DRY:          dry_next     = cfg_wdata;
                CFG_WET:          wet_next     = cfg_wdata;
                CFG_CAL_VALID:    cal_next     = cfg_wdata[0];
                CFG_MIN_INTERVAL: min_int_next = cfg_wdata;
                CFG_SAT_LEVEL:    sat_next     = cfg_wdata;
                default: ;
            endcase
        end

        case (ctl.op)
            OP_WAIT_IN: begin
                if (in_accept) begin
                    now_next    = s_tdata[TIME_W-1:0];
                    amb_next    = s_tdata[TIME_W+CNT_W-1:TIME_W];
                    lit_next    = s_tdata[TIME_W+2*CNT_W-1:TIME_W+CNT_W];
                    amb_ok_next = s_tuser[0];
                    lit_ok_next = s_tuser[1];
                end
            end
            OP_DECIDE: begin
                paper_next = 1'b0;
                moist_next = '0;
                refl_next  = '0;
                if (too_soon) begin
                    status_next = ST_TOO_FREQUENT;
                    done        = 1'b1;
                end else begin
                    if (!open_reg) begin
                        last_start_next = now_reg;
                    end
                    if (retry_read || retry_gain) begin
                        done = 1'b1;
                        if (retry_gain) begin
                            gain_next = gain_reg - GAIN_W'(1);
                        end
                        if (exhausted) begin
                            status_next = ST_FAILED;
                            open_next   = 1'b0;
                            att_next    = '0;
                        end else begin
                            status_next = retry_gain ? ST_GAIN_RETRY : ST_READ_RETRY;
                            open_next   = 1'b1;
                            att_next    = att_inc;
                        end
                    end else begin
                        refl_next   = refl;
                        paper_next  = paper;
                        status_next = min_sat ? ST_OK_MINSAT : ST_OK;
                        open_next   = 1'b0;
                        att_next    = '0;
                        done        = !paper;
                    end
                end
            end
            OP_SETUP: begin
                moist_next = '0;
                if (num_le0) begin
                    done = 1'b1;
                end else if (num_ge_den) begin
                    moist_next = MOIST_FULL;
                    done       = 1'b1;
                end else begin
                    // 1000*n/den rounded: (2000*n + den) / (2*den)
                    rem_next  = REM_W'(num[CNT_W-1:0]) * REM_W'(MOIST_SCALE) + REM_W'(den);
                    dsr_next  = DSR_W'({den, 1'b0}) << (MOIST_W - 1);
                    loop_next = DIV_LAST;
                end
            end
            OP_DIV: begin
                if (div_bit) begin
                    rem_next = div_trial;
                end
                moist_next = {moist_reg[MOIST_W-2:0], div_bit};
                dsr_next   = dsr_reg >> 1;
                loop_next  = loop_reg - LOOP_W'(1);
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_status_next = status_reg;
                    out_paper_next  = paper_reg;
                    out_moist_next  = moist_reg;
                    out_refl_next   = refl_reg;
                    out_gain_next   = gain_reg;
                end
            end
            default: ;
        endcase

        // Branch unit
        case (ctl.cond)
            COND_ALWAYS:   take = 1'b1;
            COND_NO_IN:    take = !in_accept;
            COND_DONE:     take = done;
            COND_LOOP:     take = (loop_reg != '0);
            COND_OUT_BUSY: take = !out_free;
            default:       take = 1'b1;
        endcase
        pc_next = take ? ctl.target : pc_reg + PC_W'(1);
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dry_reg        <= '0;
            wet_reg        <= '0;
            cal_reg        <= 1'b0;
            min_int_reg    <= MIN_INTERVAL_RST;
            sat_reg        <= SAT_LEVEL_RST;
            gain_reg       <= GAIN_RST;
            last_start_reg <= '0;
            open_reg       <= 1'b0;
            att_reg        <= '0;
            pc_reg         <= PC_START;
            m_valid_reg    <= 1'b0;
        end else begin
            dry_reg        <= dry_next;
            wet_reg        <= wet_next;
            cal_reg        <= cal_next;
            min_int_reg    <= min_int_next;
            sat_reg        <= sat_next;
            gain_reg       <= gain_next;
            last_start_reg <= last_start_next;
            open_reg       <= open_next;
            att_reg        <= att_next;
            pc_reg         <= pc_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        now_reg        <= now_next;
        amb_reg        <= amb_next;
        lit_reg        <= lit_next;
        amb_ok_reg     <= amb_ok_next;
        lit_ok_reg     <= lit_ok_next;
        status_reg     <= status_next;
        paper_reg      <= paper_next;
        refl_reg       <= refl_next;
        moist_reg      <= moist_next;
        rem_reg        <= rem_next;
        dsr_reg        <= dsr_next;
        loop_reg       <= loop_next;
        out_status_reg <= out_status_next;
        out_paper_reg  <= out_paper_next;
        out_moist_reg  <= out_moist_next;
        out_refl_reg   <= out_refl_next;
        out_gain_reg   <= out_gain_next;
    end

endmodule

[src/nmmu_checker.sv]
`include "nir_moisture_measure_unit_defines.svh"

module nmmu_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [nmmu_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [nmmu_pkg::OUT_USER_W-1:0]  m_tuser
);
    import nmmu_pkg::*;

    // A held result keeps its payload
    `NMMU_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Non-ok statuses carry no measurement
    `NMMU_ASSERT(a_fail_zero, aclk, aresetn, m_tvalid && (m_tuser == ST_TOO_FREQUENT || m_tuser == ST_READ_RETRY || m_tuser == ST_GAIN_RETRY || m_tuser == ST_FAILED) |-> (m_tdata[26:0] == '0), "non-ok result carries data")

    // Moisture only with paper, and within full scale
    `NMMU_ASSERT(a_moist_range, aclk, aresetn, m_tvalid |-> (m_tdata[10:1] <= MOIST_FULL) && (m_tdata[0] || (m_tdata[10:1] == '0)), "moisture out of range or without paper")

    // Status code and gain code stay in their ranges
    `NMMU_ASSERT(a_codes, aclk, aresetn, m_tvalid |-> (m_tuser <= ST_OK_MINSAT) && (m_tdata[30:27] <= GAIN_RST) && !m_tdata[31], "bad status or gain code")

    // No result while reset is held
    `NMMU_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind nir_moisture_measure_unit nmmu_checker u_nmmu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/nir_moisture_measure_unit_test.sv]
module nir_moisture_measure_unit_test;

    import nmmu_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 500000;
    localparam int unsigned DRAIN_CYCLES    = 40;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned ITEMS_PER_PHASE = 185;
    localparam int unsigned MAX_REPORTS     = 100;

    // One result item, field by field
    typedef struct packed {
        status_t              status;
        logic                 paper;
        logic [MOIST_W-1:0]   moist;
        logic [CNT_W-1:0]     refl;
        logic [GAIN_W-1:0]    gain;
    } measure_result_t;

    // One row of the directed table: a register write or a measurement
    typedef struct {
        bit                   is_cfg;
        cfg_index_t           idx;
        logic [CNT_W-1:0]     wdata;
        logic [TIME_W-1:0]    now;
        logic [CNT_W-1:0]     amb;
        logic [CNT_W-1:0]     lit;
        bit                   aok;
        bit                   lok;
        bit                   known;
        measure_result_t      exp;
    } stim_row_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    // tdata: now_ms[31:0], ambient_nir[47:32], lit_nir[63:48]
    logic [IN_DATA_W-1:0]     s_tdata   = '0;
    // tuser: ambient_ok[0], lit_ok[1]
    logic [IN_USER_W-1:0]     s_tuser   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    // tdata: paper_detected[0], moisture_tenths[10:1], reflected_nir[26:11],
    //        gain_setting[30:27], zero[31]
    logic [OUT_DATA_W-1:0]    m_tdata;
    // tuser: status[2:0]
    logic [OUT_USER_W-1:0]    m_tuser;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_DRY;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

    nir_moisture_measure_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow registers and measurement state
    logic [CNT_W-1:0]         dry_reg;
    logic [CNT_W-1:0]         wet_reg;
    logic                     cal_on;
    logic [CNT_W-1:0]         interval_reg;
    logic [CNT_W-1:0]         sat_reg;
    logic [GAIN_W-1:0]        model_gain;
    logic [TIME_W-1:0]        model_last_start;
    logic                     model_open;
    logic [ATT_W-1:0]         model_attempts;

    measure_result_t          pending_results[$];

    int unsigned              send_idle = 10;
    int unsigned              recv_idle = 57;
    int unsigned              errors = 0;
    int unsigned              items_sent = 0;
    int unsigned              results_seen = 0;
    int unsigned              cfg_writes = 0;
    int unsigned              status_seen[8];

    // Clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Moisture in tenths of a percent, rounded to nearest
    function automatic logic [MOIST_W-1:0] moisture_for(input logic [CNT_W-1:0] refl);
        longint d;
        longint w;
        longint n;
        longint span;
        d = longint'(DEF_DRY);
        w = longint'(DEF_WET);
        if (cal_on && dry_reg > wet_reg) begin
            d = longint'(dry_reg);
            w = longint'(wet_reg);
        end
        span = d - w;
        n = d - longint'(refl);
        if (n <= 0)
            return '0;
        if (n >= span)
            return MOIST_FULL;
        return MOIST_W'((2000 * n + span) / (2 * span));
    endfunction

    // Saturated reading: step the gain down, or note it when already at minimum
    function automatic bit lowers_gain(input logic [CNT_W-1:0] v, inout bit minsat);
        if (v < sat_reg)
            return 1'b0;
        if (model_gain != '0) begin
            model_gain = model_gain - 1'b1;
            return 1'b1;
        end
        minsat = 1'b1;
        return 1'b0;
    endfunction

    // Expected result of one measurement attempt; advances the shadow state
    function automatic measure_result_t predict_measurement(
        input logic [TIME_W-1:0] now,
        input logic [CNT_W-1:0]  amb,
        input logic [CNT_W-1:0]  lit,
        input bit                aok,
        input bit                lok
    );
        measure_result_t  r;
        status_t          retry;
        bit               minsat;
        logic [CNT_W-1:0] refl;
        r = '0;
        retry = ST_OK;
        minsat = 1'b0;
        // Interval check only when a new measurement starts
        if (!model_open) begin
            if ((now - model_last_start) < TIME_W'(interval_reg)) begin
                r.status = ST_TOO_FREQUENT;
                r.gain = model_gain;
                return r;
            end
            model_last_start = now;
            model_open = 1'b1;
            model_attempts = '0;
        end
        if (!aok)
            retry = ST_READ_RETRY;
        else if (lowers_gain(amb, minsat))
            retry = ST_GAIN_RETRY;
        else if (!lok)
            retry = ST_READ_RETRY;
        else if (lowers_gain(lit, minsat))
            retry = ST_GAIN_RETRY;
        if (retry != ST_OK) begin
            model_attempts = model_attempts + 1'b1;
            if (model_attempts >= MAX_ATTEMPTS) begin
                r.status = ST_FAILED;
                model_open = 1'b0;
                model_attempts = '0;
            end else begin
                r.status = retry;
            end
            r.gain = model_gain;
            return r;
        end
        refl = (lit > amb) ? lit - amb : '0;
        r.refl = refl;
        r.paper = (2 * int'(refl)) > (3 * int'(amb));
        r.moist = r.paper ? moisture_for(refl) : '0;
        r.status = minsat ? ST_OK_MINSAT : ST_OK;
        r.gain = model_gain;
        model_open = 1'b0;
        model_attempts = '0;
        return r;
    endfunction

    function automatic stim_row_t meas_row(
        input logic [TIME_W-1:0] now,
        input logic [CNT_W-1:0]  amb,
        input logic [CNT_W-1:0]  lit,
        input bit                aok,
        input bit                lok
    );
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.idx = CFG_DRY;
        r.wdata = '0;
        r.now = now;
        r.amb = amb;
        r.lit = lit;
        r.aok = aok;
        r.lok = lok;
        r.known = 1'b0;
        r.exp = '0;
        return r;
    endfunction

    // Row whose result is written out by hand
    function automatic stim_row_t known_row(
        input logic [TIME_W-1:0]  now,
        input logic [CNT_W-1:0]   amb,
        input logic [CNT_W-1:0]   lit,
        input bit                 aok,
        input bit                 lok,
        input status_t            st,
        input logic               paper,
        input logic [MOIST_W-1:0] moist,
        input logic [CNT_W-1:0]   refl,
        input logic [GAIN_W-1:0]  gain
    );
        stim_row_t r;
        r = meas_row(now, amb, lit, aok, lok);
        r.known = 1'b1;
        r.exp = '{status: st, paper: paper, moist: moist, refl: refl, gain: gain};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input cfg_index_t idx, input logic [CNT_W-1:0] v);
        stim_row_t r;
        r = meas_row('0, '0, '0, 1'b0, 1'b0);
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.wdata = v;
        return r;
    endfunction

    // Offer one item, wait for acceptance, then queue its expected result
    task automatic send_measurement(
        input logic [TIME_W-1:0] now,
        input logic [CNT_W-1:0]  amb,
        input logic [CNT_W-1:0]  lit,
        input bit                aok,
        input bit                lok,
        input bit                known,
        input measure_result_t   known_result
    );
        measure_result_t predicted;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = {lit, amb, now};
        s_tuser = {lok, aok};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_measurement(now, amb, lit, aok, lok);
        pending_results.push_back(known ? known_result : predicted);
        items_sent++;
    endtask

    // Drop valid and wait until every queued result has been taken
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CNT_W-1:0] value);
        @(negedge aclk);
        cfg_index = idx;
        cfg_wdata = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DRY:          dry_reg = value;
            CFG_WET:          wet_reg = value;
            CFG_CAL_VALID:    cal_on = value[0];
            CFG_MIN_INTERVAL: interval_reg = value;
            CFG_SAT_LEVEL:    sat_reg = value;
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Mostly well-timed measurements with plausible counts, some noise
    task automatic send_random_measurement();
        logic [TIME_W-1:0] now;
        logic [CNT_W-1:0]  amb;
        logic [CNT_W-1:0]  lit;
        int unsigned       roll;
        int unsigned       span;
        int unsigned       lit_sum;
        bit                aok;
        bit                lok;
        roll = $urandom_range(0, 99);
        if (model_open)
            now = model_last_start + $urandom_range(0, 2000);
        else if (roll < 10)
            now = $urandom;
        else if (roll < 25)
            now = model_last_start + $urandom_range(0, interval_reg);
        else
            now = model_last_start + interval_reg + $urandom_range(0, 3000);
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            amb = CNT_W'($urandom);
            lit = CNT_W'($urandom);
        end else begin
            span = (cal_on && dry_reg > wet_reg) ? dry_reg + 100 : DEF_DRY + 200;
            amb = CNT_W'($urandom_range(0, 400));
            lit_sum = amb + $urandom_range(0, span);
            lit = (lit_sum > 65535) ? 16'hFFFF : lit_sum[15:0];
        end
        // Occasional saturated reading on either channel
        roll = $urandom_range(0, 99);
        if (roll < 2)
            amb = CNT_W'(sat_reg + $urandom_range(0, 65535 - sat_reg));
        else if (roll < 5)
            lit = CNT_W'(sat_reg + $urandom_range(0, 65535 - sat_reg));
        aok = $urandom_range(0, 99) < 92;
        lok = $urandom_range(0, 99) < 92;
        send_measurement(now, amb, lit, aok, lok, 1'b0, '0);
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endtask

    // Receiver stalls
    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= recv_idle);
    end

    // Compare each result item with the oldest expectation
    always @(posedge aclk) begin : result_check
        measure_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            status_seen[m_tuser]++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result item with nothing expected, status %0d", $time, m_tuser);
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("paper_detected", want.paper, m_tdata[0]);
                check_field("moisture_tenths", want.moist, m_tdata[10:1]);
                check_field("reflected_nir", want.refl, m_tdata[26:11]);
                check_field("gain_setting", want.gain, m_tdata[30:27]);
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int unsigned cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge aclk);
        $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        stim_row_t   dir_rows[$];
        int unsigned p;
        int unsigned k;

        // Shadow state after reset
        dry_reg = '0;
        wet_reg = '0;
        cal_on = 1'b0;
        interval_reg = MIN_INTERVAL_RST;
        sat_reg = SAT_LEVEL_RST;
        model_gain = GAIN_RST;
        model_last_start = '0;
        model_open = 1'b0;
        model_attempts = '0;

        // Reset values: interval 500, saturation at full scale, gain 7
        dir_rows.push_back(known_row(0, 0, 0, 1, 1, ST_TOO_FREQUENT, 0, 0, 0, 7));
        dir_rows.push_back(known_row(499, 16'hFFFF, 16'hFFFF, 1, 1, ST_TOO_FREQUENT, 0, 0, 0, 7));
        dir_rows.push_back(known_row(500, 100, 200, 0, 1, ST_READ_RETRY, 0, 0, 0, 7));
        dir_rows.push_back(known_row(777, 16'hFFFF, 0, 1, 1, ST_GAIN_RETRY, 0, 0, 0, 6));
        dir_rows.push_back(known_row(778, 0, 0, 1, 0, ST_FAILED, 0, 0, 0, 6));
        dir_rows.push_back(known_row(1000, 100, 1600, 1, 1, ST_OK, 1, 0, 1500, 6));
        dir_rows.push_back(known_row(1500, 0, 300, 1, 1, ST_OK, 1, 1000, 300, 6));
        dir_rows.push_back(known_row(2000, 0, 0, 1, 1, ST_OK, 0, 0, 0, 6));
        dir_rows.push_back(known_row(2500, 1000, 500, 1, 1, ST_OK, 0, 0, 0, 6));
        dir_rows.push_back(known_row(3000, 0, 16'hFFFF, 1, 1, ST_GAIN_RETRY, 0, 0, 0, 5));
        dir_rows.push_back(known_row(3001, 10, 910, 1, 1, ST_OK, 1, 500, 900, 5));
        // Time wraps past the top of the counter
        dir_rows.push_back(meas_row(32'hFFFF_FFFF, 4000, 9000, 1, 1));
        dir_rows.push_back(meas_row(32'h0000_0100, 200, 1000, 1, 1));
        dir_rows.push_back(meas_row(32'h0000_01F3, 200, 1000, 1, 1));
        dir_rows.push_back(meas_row(1200, 50, 0, 1, 0));
        // Everything saturates: gain walks down to minimum, then reports it
        dir_rows.push_back(cfg_row(CFG_SAT_LEVEL, 0));
        dir_rows.push_back(cfg_row(CFG_MIN_INTERVAL, 0));
        for (k = 0; k < 6; k++)
            dir_rows.push_back(meas_row(5000 + k, 5, 300, 1, 1));
        // Calibrated baselines, their extremes, and dry below wet
        dir_rows.push_back(cfg_row(CFG_SAT_LEVEL, 16'hFFFF));
        dir_rows.push_back(cfg_row(CFG_CAL_VALID, 1));
        dir_rows.push_back(cfg_row(CFG_DRY, 1000));
        dir_rows.push_back(cfg_row(CFG_WET, 200));
        dir_rows.push_back(meas_row(6000, 0, 600, 1, 1));
        dir_rows.push_back(cfg_row(CFG_DRY, 16'hFFFF));
        dir_rows.push_back(cfg_row(CFG_WET, 0));
        dir_rows.push_back(meas_row(6001, 0, 16'hFFFE, 1, 1));
        dir_rows.push_back(meas_row(6002, 0, 1, 1, 1));
        dir_rows.push_back(cfg_row(CFG_DRY, 200));
        dir_rows.push_back(cfg_row(CFG_WET, 1000));
        dir_rows.push_back(meas_row(6003, 0, 900, 1, 1));
        dir_rows.push_back(meas_row(6004, 16'hFFFE, 16'hFFFE, 1, 1));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                wait_drained();
                write_register(dir_rows[i].idx, dir_rows[i].wdata);
            end else begin
                send_measurement(dir_rows[i].now, dir_rows[i].amb, dir_rows[i].lit,
                                 dir_rows[i].aok, dir_rows[i].lok,
                                 dir_rows[i].known, dir_rows[i].exp);
            end
        end

        // Random phases, each under its own register setting
        for (p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            case (p / 2)
                0: begin
                    send_idle = 10;
                    recv_idle = 57;
                end
                1: begin
                    send_idle = 57;
                    recv_idle = 10;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            if (p == 0) begin
                write_register(CFG_DRY, 16'hFFFF);
                write_register(CFG_WET, 0);
                write_register(CFG_CAL_VALID, 1);
                write_register(CFG_MIN_INTERVAL, 0);
                write_register(CFG_SAT_LEVEL, 16'hFFFF);
            end else if (p == 1) begin
                write_register(CFG_DRY, 0);
                write_register(CFG_WET, 16'hFFFF);
                write_register(CFG_CAL_VALID, 1);
                write_register(CFG_MIN_INTERVAL, 16'hFFFF);
                write_register(CFG_SAT_LEVEL, CNT_W'($urandom_range(30000, 65535)));
            end else begin
                write_register(CFG_DRY, CNT_W'($urandom_range(600, 5000)));
                write_register(CFG_WET, CNT_W'($urandom_range(0, 700)));
                write_register(CFG_CAL_VALID, CNT_W'(p % 2));
                write_register(CFG_MIN_INTERVAL,
                               (p == 3) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 1000)));
                write_register(CFG_SAT_LEVEL,
                               (p == 4) ? CNT_W'($urandom) : CNT_W'($urandom_range(20000, 65535)));
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // In the first phase only, hold off once mid-phase until the block has emptied out
                if (p == 0 && k == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_random_measurement();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d measurement items (%0d directed) with %0d register writes;",
                 items_sent, dir_rows.size() - cfg_writes + 30, cfg_writes);
        $display("%0d results checked", results_seen);
        $display("Statuses: ok %0d, too frequent %0d, read retry %0d, gain retry %0d,",
                 status_seen[ST_OK], status_seen[ST_TOO_FREQUENT], status_seen[ST_READ_RETRY],
                 status_seen[ST_GAIN_RETRY]);
        $display("failed %0d, min gain %0d",
                 status_seen[ST_FAILED], status_seen[ST_OK_MINSAT]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
